### design/rmeu_pkg.sv
package rmeu_pkg;

    localparam int STORE_WORDS   = 256;
    localparam int PROGRAM_WORDS = 4096;
    localparam int ADDR_W        = $clog2(STORE_WORDS);
    localparam int LOC_W         = 9;
    localparam int TGT_W         = 12;
    localparam int CONT_W        = 13;

    localparam logic [2:0] FLAG_EQ = 3'h1;
    localparam logic [2:0] FLAG_GT = 3'h2;
    localparam logic [2:0] FLAG_LT = 3'h4;

    typedef enum logic [4:0] {
        OP_MOV = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_SAR = 5'd3, OP_SAL = 5'd4,
        OP_MUL = 5'd5, OP_DIV = 5'd6, OP_AND = 5'd7, OP_OR = 5'd8, OP_XOR = 5'd9,
        OP_CMP = 5'd10, OP_SEQ = 5'd11, OP_SNE = 5'd12, OP_SGE = 5'd13,
        OP_SGT = 5'd14, OP_SLE = 5'd15, OP_SLT = 5'd16, OP_PRINT = 5'd17,
        OP_NEG = 5'd18, OP_NOT = 5'd19, OP_JMP = 5'd20, OP_JE = 5'd21
    } op_t;

    typedef struct packed {
        logic [4:0]        mode;
        logic [LOC_W-1:0]  dest_location;
        logic [LOC_W-1:0]  src_location;
        logic              src_is_immediate;
        logic signed [31:0] src_immediate;
        logic [TGT_W-1:0]  jump_target;
    } in_word_t;

    typedef struct packed {
        logic               jump_taken;
        logic [CONT_W-1:0]  continue_at;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic               divide_by_zero;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_WRITE, ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic load;
        logic exec;
        logic div_start;
        logic div_step;
        logic write;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic is_div;
        logic div_done;
    } status_t;

endpackage

### design/rmeu_datapath.sv
module rmeu_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  rmeu_pkg::cmd_t     cmd,
    output rmeu_pkg::status_t  status,
    input  rmeu_pkg::in_word_t in_word,
    output rmeu_pkg::out_word_t out_word
);

    logic [31:0] mem [rmeu_pkg::STORE_WORDS];
    logic [31:0] rd_d_reg, rd_s_reg;
    logic [rmeu_pkg::ADDR_W:0] clr_reg;
    rmeu_pkg::in_word_t ins_reg;
    logic [31:0] ax_reg, bx_reg;
    logic [2:0]  flags_reg;
    logic [31:0] d_val, s_val;
    logic [31:0] res_reg;
    logic        wr_reg;
    logic        wr_next;
    rmeu_pkg::out_word_t res_out_reg;
    rmeu_pkg::out_word_t res_out_next;
    logic [rmeu_pkg::LOC_W-1:0] d_off, s_off;
    logic        d_in, s_in;

    // divider state
    logic [31:0] q_reg, r_reg, dvs_reg;
    logic [5:0]  cnt_reg;
    logic        qneg_reg;
    logic [32:0] trial;

    assign d_off = ins_reg.dest_location - rmeu_pkg::LOC_W'(2);
    assign s_off = ins_reg.src_location - rmeu_pkg::LOC_W'(2);
    assign d_in  = ins_reg.dest_location >= rmeu_pkg::LOC_W'(2)
                && d_off < rmeu_pkg::LOC_W'(rmeu_pkg::STORE_WORDS);
    assign s_in  = ins_reg.src_location >= rmeu_pkg::LOC_W'(2)
                && s_off < rmeu_pkg::LOC_W'(rmeu_pkg::STORE_WORDS);

    // memory: clear sweep, write-back, registered reads
    always_ff @(posedge aclk) begin
        if (cmd.clear_en) begin
            mem[clr_reg[rmeu_pkg::ADDR_W-1:0]] <= '0;
        end else if (cmd.write && wr_reg && d_in) begin
            mem[d_off[rmeu_pkg::ADDR_W-1:0]] <= res_reg;
        end
        rd_d_reg <= mem[d_off[rmeu_pkg::ADDR_W-1:0]];
        rd_s_reg <= mem[s_off[rmeu_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear_en) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end
    assign status.clear_done = clr_reg == (rmeu_pkg::ADDR_W+1)'(rmeu_pkg::STORE_WORDS - 1)
                             && cmd.clear_en;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ins_reg <= in_word;
        end
    end

    always_comb begin
        if (ins_reg.dest_location == '0)                     d_val = ax_reg;
        else if (ins_reg.dest_location == rmeu_pkg::LOC_W'(1)) d_val = bx_reg;
        else if (d_in)                                       d_val = rd_d_reg;
        else                                                 d_val = '0;
        if (ins_reg.src_is_immediate)                        s_val = ins_reg.src_immediate;
        else if (ins_reg.src_location == '0)                 s_val = ax_reg;
        else if (ins_reg.src_location == rmeu_pkg::LOC_W'(1))  s_val = bx_reg;
        else if (s_in)                                       s_val = rd_s_reg;
        else                                                 s_val = '0;
    end

    // operations that write the destination back
    always_comb begin
        case (ins_reg.mode)
            rmeu_pkg::OP_MOV, rmeu_pkg::OP_ADD, rmeu_pkg::OP_SUB, rmeu_pkg::OP_SAR,
            rmeu_pkg::OP_SAL, rmeu_pkg::OP_MUL, rmeu_pkg::OP_AND, rmeu_pkg::OP_OR,
            rmeu_pkg::OP_XOR, rmeu_pkg::OP_SEQ, rmeu_pkg::OP_SNE, rmeu_pkg::OP_SGE,
            rmeu_pkg::OP_SGT, rmeu_pkg::OP_SLE, rmeu_pkg::OP_SLT, rmeu_pkg::OP_NEG,
            rmeu_pkg::OP_NOT: wr_next = 1'b1;
            rmeu_pkg::OP_DIV: wr_next = s_val != '0;
            default:          wr_next = 1'b0;
        endcase
    end

    assign status.is_div = ins_reg.mode == rmeu_pkg::OP_DIV && s_val != '0;
    assign status.div_done = cnt_reg == 6'd32;
    assign trial = {r_reg[31:0], q_reg[31]} - {1'b0, dvs_reg};

    // restoring divider on magnitudes, one bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_start) begin
            cnt_reg <= '0;
            q_reg   <= d_val[31] ? 32'(-d_val) : d_val;
            dvs_reg <= s_val[31] ? 32'(-s_val) : s_val;
            r_reg   <= '0;
            qneg_reg <= d_val[31] ^ s_val[31];
        end else if (cmd.div_step && !status.div_done) begin
            cnt_reg <= cnt_reg + 6'd1;
            if (!trial[32]) begin
                r_reg <= trial[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end else begin
                r_reg <= {r_reg[30:0], q_reg[31]};
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    always_comb begin
        res_out_next = '0;
        case (ins_reg.mode)
            rmeu_pkg::OP_PRINT: begin
                res_out_next.print_valid = 1'b1;
                res_out_next.print_value = d_val;
            end
            rmeu_pkg::OP_DIV:  res_out_next.divide_by_zero = s_val == '0;
            rmeu_pkg::OP_JMP:  res_out_next.jump_taken = 1'b1;
            rmeu_pkg::OP_JE:   res_out_next.jump_taken = flags_reg[0];
            default: ;
        endcase
        if (res_out_next.jump_taken) begin
            res_out_next.continue_at = (ins_reg.jump_target >=
                rmeu_pkg::TGT_W'(rmeu_pkg::PROGRAM_WORDS - 1))
                ? rmeu_pkg::CONT_W'(rmeu_pkg::PROGRAM_WORDS)
                : rmeu_pkg::CONT_W'(ins_reg.jump_target) + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ax_reg <= '0;
            bx_reg <= '0;
            flags_reg <= '0;
            wr_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                wr_reg <= wr_next;
                res_out_reg <= res_out_next;
                case (ins_reg.mode)
                    rmeu_pkg::OP_MOV: res_reg <= s_val;
                    rmeu_pkg::OP_ADD: res_reg <= d_val + s_val;
                    rmeu_pkg::OP_SUB: res_reg <= d_val - s_val;
                    rmeu_pkg::OP_SAR: res_reg <= $signed(d_val) >>> s_val[4:0];
                    rmeu_pkg::OP_SAL: res_reg <= d_val << s_val[4:0];
                    rmeu_pkg::OP_MUL: res_reg <= d_val * s_val;
                    rmeu_pkg::OP_AND: res_reg <= d_val & s_val;
                    rmeu_pkg::OP_OR:  res_reg <= d_val | s_val;
                    rmeu_pkg::OP_XOR: res_reg <= d_val ^ s_val;
                    rmeu_pkg::OP_SEQ: res_reg <= 32'(flags_reg[0]);
                    rmeu_pkg::OP_SNE: res_reg <= 32'(!flags_reg[0]);
                    rmeu_pkg::OP_SGE: res_reg <= 32'(flags_reg[0] | flags_reg[1]);
                    rmeu_pkg::OP_SGT: res_reg <= 32'(flags_reg[1]);
                    rmeu_pkg::OP_SLE: res_reg <= 32'(flags_reg[0] | flags_reg[2]);
                    rmeu_pkg::OP_SLT: res_reg <= 32'(flags_reg[2]);
                    rmeu_pkg::OP_NEG: res_reg <= 32'(-d_val);
                    rmeu_pkg::OP_NOT: res_reg <= ~d_val;
                    default: ;
                endcase
                if (ins_reg.mode == rmeu_pkg::OP_CMP) begin
                    if ($signed(d_val) > $signed(s_val))      flags_reg <= rmeu_pkg::FLAG_GT;
                    else if ($signed(d_val) < $signed(s_val)) flags_reg <= rmeu_pkg::FLAG_LT;
                    else                                      flags_reg <= rmeu_pkg::FLAG_EQ;
                end
            end
            if (cmd.div_step && status.div_done) begin
                res_reg <= qneg_reg ? 32'(-q_reg) : q_reg;
            end
            if (cmd.write && wr_reg) begin
                if (ins_reg.dest_location == '0)                       ax_reg <= res_reg;
                else if (ins_reg.dest_location == rmeu_pkg::LOC_W'(1)) bx_reg <= res_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_word <= res_out_reg;
        end
    end

endmodule

### design/rmeu_control.sv
module rmeu_control (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  rmeu_pkg::status_t status,
    output rmeu_pkg::cmd_t    cmd
);

    rmeu_pkg::state_t state_reg, state_next;
    logic mv_reg, mv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rmeu_pkg::ST_CLEAR;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        mv_next = mv_reg && !m_ready;
        case (state_reg)
            rmeu_pkg::ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_done) state_next = rmeu_pkg::ST_IDLE;
            end
            rmeu_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = rmeu_pkg::ST_READ;
                end
            end
            rmeu_pkg::ST_READ: state_next = rmeu_pkg::ST_EXEC;
            rmeu_pkg::ST_EXEC: begin
                cmd.exec = 1'b1;
                if (status.is_div) begin
                    cmd.div_start = 1'b1;
                    state_next = rmeu_pkg::ST_DIV;
                end else begin
                    state_next = rmeu_pkg::ST_WRITE;
                end
            end
            rmeu_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) state_next = rmeu_pkg::ST_WRITE;
            end
            rmeu_pkg::ST_WRITE: begin
                cmd.write = 1'b1;
                state_next = rmeu_pkg::ST_OUT;
            end
            rmeu_pkg::ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    mv_next = 1'b1;
                    state_next = rmeu_pkg::ST_IDLE;
                end
            end
            default: state_next = rmeu_pkg::ST_IDLE;
        endcase
    end

endmodule

### design/register_machine_execute_unit.sv
// register_machine_execute_unit: one instruction per accepted word
// sequence: an accepted word passes the read, execute, optional divide, write-back
//   and output states before its result is valid; no new word is taken before then,
//   the pace set by the read / execute / write-back sequence through the word store port
//   and the one-bit-per-cycle divider; a result word still held by m_ready adds its stall
// reset: synchronous active low; then a clearing pass over all 256 words of the word store
module register_machine_execute_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rmeu_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rmeu_pkg::out_word_t m_data
);

    // command and status between controller and datapath
    rmeu_pkg::cmd_t    cmd;
    rmeu_pkg::status_t status;

    // sequencer: clear pass, then read, execute, optional divide, write-back, output
    rmeu_control u_control (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // registers, word store, alu, divider and output register
    rmeu_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .in_word  (s_data),
        .out_word (m_data)
    );

endmodule
